[sv/mfpm_pkg.sv]
// Package: widths, kind codes and sizes for the mesh face pair matcher.
`default_nettype none
package mfpm_pkg;
  localparam int unsigned TableEntries = 256;
  localparam int unsigned IdxW = $clog2(TableEntries);
  localparam int unsigned CntW = $clog2(TableEntries + 1);
  localparam int unsigned IdW = 32;
  localparam int unsigned KindW = 3;

  localparam logic [KindW-1:0] KindStored   = 3'd0;
  localparam logic [KindW-1:0] KindMatched  = 3'd1;
  localparam logic [KindW-1:0] KindBoundary = 3'd2;
  localparam logic [KindW-1:0] KindFull     = 3'd3;
  localparam logic [KindW-1:0] KindEmpty    = 3'd4;

  localparam logic OpPresent = 1'b0;
  localparam logic OpDrain   = 1'b1;

  typedef struct packed {
    logic [IdW-1:0] elem;
    logic [IdW-1:0] opp;
    logic [IdW-1:0] va;
    logic [IdW-1:0] vb;
    logic [IdW-1:0] vc;
    logic [IdW-1:0] vd;
  } owner_t;
endpackage
`default_nettype wire

[sv/mesh_face_pair_matcher.sv]
// Top level: open-face table with a sequential scan for face pairing and boundary drain.
//
//  channel | valid     | stall     | payload
//  in      | in_valid_i| in_stall_o| op_i, face_vert_*_i, element_id_i, opposite_vertex_i
//  out     | out_valid_o| out_stall_i| kind_o, element_*_o, opposite_*_o, out_vert_*_o
//
// A present beat sorts its vertices on one compare-swap unit, then scans the single-port
// key memory one entry at a time (registered read, compare): a hit ends the scan at that
// entry, a miss scans every entry and then passes the store state before the result.
// A drain skips the sort and returns the lowest valid entry, or an empty result if none.
// Reset clears the valid bits at once; no clearing pass is needed.
// in_stall_o is high from acceptance until the result beat has been taken.
`default_nettype none
module mesh_face_pair_matcher (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        op_i,
  input  wire logic [31:0] face_vert_a_i,
  input  wire logic [31:0] face_vert_b_i,
  input  wire logic [31:0] face_vert_c_i,
  input  wire logic [31:0] face_vert_d_i,
  input  wire logic [31:0] element_id_i,
  input  wire logic [31:0] opposite_vertex_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       kind_o,
  output logic [31:0]      element_down_o,
  output logic [31:0]      element_up_o,
  output logic [31:0]      opposite_down_o,
  output logic [31:0]      opposite_up_o,
  output logic [31:0]      out_vert_a_o,
  output logic [31:0]      out_vert_b_o,
  output logic [31:0]      out_vert_c_o,
  output logic [31:0]      out_vert_d_o
);
  localparam int unsigned IdxW = mfpm_pkg::IdxW;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StSort = 3'd1;
  localparam logic [2:0] StScan = 3'd2;
  localparam logic [2:0] StChk  = 3'd3;
  localparam logic [2:0] StFree = 3'd4;
  localparam logic [2:0] StOut  = 3'd5;

  logic [2:0] state_q, state_d;
  logic op_q;
  logic [31:0] s_q [4];
  logic [2:0] step_q;
  logic [IdxW-1:0] idx_q;
  logic [IdxW-1:0] free_q;
  logic free_found_q;
  logic [mfpm_pkg::TableEntries-1:0] valid_q;
  mfpm_pkg::owner_t cur_q;

  logic [127:0] key_mem [mfpm_pkg::TableEntries];
  mfpm_pkg::owner_t own_mem [mfpm_pkg::TableEntries];
  logic [127:0] key_rd_q;
  mfpm_pkg::owner_t own_rd_q;
  logic rd_valid_q;
  logic [IdxW-1:0] rd_idx_q;

  logic [2:0] kind_q;
  mfpm_pkg::owner_t res_q;
  logic [31:0] eup_q, oup_q;

  logic accept_in, accept_out;
  assign accept_in  = in_valid_i && !in_stall_o;
  assign accept_out = out_valid_o && !out_stall_i;
  assign in_stall_o = (state_q != StIdle);
  assign out_valid_o = (state_q == StOut);

  // one compare-swap unit, bubble order (0,1) (1,2) (2,3) (0,1) (1,2) (0,1)
  logic [1:0] cs_lo;
  logic cs_swap;
  always_comb begin
    unique case (step_q)
      3'd1, 3'd4: cs_lo = 2'd1;
      3'd2:       cs_lo = 2'd2;
      default:    cs_lo = 2'd0;
    endcase
    cs_swap = s_q[cs_lo] > s_q[cs_lo + 2'd1];
  end

  logic key_hit;
  assign key_hit = rd_valid_q && (key_rd_q == {s_q[3], s_q[2], s_q[1], s_q[0]});

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (accept_in) state_d = (op_i == mfpm_pkg::OpDrain) ? StScan : StSort;
      StSort: if (step_q == 3'd5) state_d = StScan;
      StScan: state_d = StChk;
      StChk:  state_d = StScan;
      StFree: state_d = StOut;
      StOut:  if (accept_out) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StScan) begin
      key_rd_q <= key_mem[idx_q];
      own_rd_q <= own_mem[idx_q];
    end
    if (state_q == StFree && kind_q == mfpm_pkg::KindStored) begin
      key_mem[free_q] <= {s_q[3], s_q[2], s_q[1], s_q[0]};
      own_mem[free_q] <= cur_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      valid_q <= '0;
      step_q <= '0;
      idx_q <= '0;
      free_found_q <= 1'b0;
      free_q <= '0;
      op_q <= 1'b0;
      rd_valid_q <= 1'b0;
      rd_idx_q <= '0;
      kind_q <= '0;
      s_q <= '{default: '0};
      cur_q <= '0;
      res_q <= '0;
      eup_q <= '0;
      oup_q <= '0;
    end else begin
      priority case (state_q)
        StIdle: if (accept_in) begin
          op_q <= op_i;
          s_q[0] <= face_vert_a_i; s_q[1] <= face_vert_b_i;
          s_q[2] <= face_vert_c_i; s_q[3] <= face_vert_d_i;
          cur_q <= '{element_id_i, opposite_vertex_i, face_vert_a_i,
                     face_vert_b_i, face_vert_c_i, face_vert_d_i};
          step_q <= '0;
          idx_q <= '0;
          free_found_q <= 1'b0;
        end
        StSort: begin
          if (cs_swap) begin
            s_q[cs_lo] <= s_q[cs_lo + 2'd1];
            s_q[cs_lo + 2'd1] <= s_q[cs_lo];
          end
          step_q <= step_q + 3'd1;
        end
        StScan: begin
          rd_valid_q <= valid_q[idx_q];
          rd_idx_q <= idx_q;
        end
        StChk: begin
          if (op_q == mfpm_pkg::OpDrain) begin
            if (rd_valid_q) begin
              valid_q[rd_idx_q] <= 1'b0;
              kind_q <= mfpm_pkg::KindBoundary;
              res_q <= own_rd_q; eup_q <= '0; oup_q <= '0;
              state_q <= StOut;
            end else if (idx_q == IdxW'(mfpm_pkg::TableEntries - 1)) begin
              kind_q <= mfpm_pkg::KindEmpty;
              res_q <= '0; eup_q <= '0; oup_q <= '0;
              state_q <= StOut;
            end else begin
              idx_q <= idx_q + 1'b1;
              state_q <= StScan;
            end
          end else begin
            if (key_hit) begin
              valid_q[rd_idx_q] <= 1'b0;
              kind_q <= mfpm_pkg::KindMatched;
              res_q <= own_rd_q; eup_q <= cur_q.elem; oup_q <= cur_q.opp;
              state_q <= StOut;
            end else begin
              if (!rd_valid_q && !free_found_q) begin
                free_found_q <= 1'b1;
                free_q <= rd_idx_q;
              end
              if (idx_q == IdxW'(mfpm_pkg::TableEntries - 1)) begin
                res_q <= cur_q; eup_q <= '0; oup_q <= '0;
                if (free_found_q || !rd_valid_q) begin
                  kind_q <= mfpm_pkg::KindStored;
                end else kind_q <= mfpm_pkg::KindFull;
                state_q <= StFree;
              end else begin
                idx_q <= idx_q + 1'b1;
                state_q <= StScan;
              end
            end
          end
        end
        StFree: begin
          if (kind_q == mfpm_pkg::KindStored) valid_q[free_q] <= 1'b1;
          state_q <= StOut;
        end
        StOut: if (accept_out) state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
      if (state_q == StIdle || state_q == StSort || state_q == StScan) state_q <= state_d;
    end
  end

  assign kind_o = kind_q;
  assign element_down_o = res_q.elem;
  assign opposite_down_o = res_q.opp;
  assign element_up_o = eup_q;
  assign opposite_up_o = oup_q;
  assign out_vert_a_o = res_q.va;
  assign out_vert_b_o = res_q.vb;
  assign out_vert_c_o = res_q.vc;
  assign out_vert_d_o = res_q.vd;

  a_out_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (kind_o <= mfpm_pkg::KindEmpty)) else $error("bad kind");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("ready while result pending");
  a_up_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o != mfpm_pkg::KindMatched) |-> (element_up_o == '0))
    else $error("up field set");
endmodule
`default_nettype wire
